// ----- src/htfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
// No dependencies; imported by every module of the block.
package htfd_pkg;

    // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final XOR
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion constants
    localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic [13:0]        HUMI_SCALE  = 14'd10000;

    // Output ranges
    localparam logic signed [14:0] TEMP_MIN = -15'sd4500;
    localparam logic signed [14:0] TEMP_MAX = 15'sd12999;
    localparam logic [13:0]        HUMI_MAX = 14'd9999;

    // Position of a byte within the six-byte reply
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } frame_pos_t;

    // What the frame tracker reports about the byte it is looking at
    typedef struct packed {
        logic        last_byte;  // byte closes a frame and yields a result
        logic        temp_ok;
        logic        humi_ok;
        logic [15:0] raw_temp;
        logic [15:0] raw_humi;
    } frame_res_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- src/htfd_frame.sv -----
// Frame tracker: byte position, running CRC and word assembly for the six-byte reply.
// Depends on htfd_pkg.
module htfd_frame
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output frame_res_t res
);

    frame_pos_t  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next, crc_seed;
    logic [15:0] word_reg, word_next;
    logic [15:0] raw_temp_reg, raw_temp_next;
    logic        temp_flag_reg, temp_flag_next;

    // Restart on a start mark or an out-of-range position
    always_comb
    begin
        if (frame_start || (pos_reg > POS_H_CRC))
        begin
            pos_eff = POS_T_HI;
        end
        else
        begin
            pos_eff = pos_reg;
        end
    end

    assign crc_seed = ((pos_eff == POS_T_HI) || (pos_eff == POS_H_HI)) ? CRC_INIT : crc_reg;

    // Next state
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        word_next      = word_reg;
        raw_temp_next  = raw_temp_reg;
        temp_flag_next = temp_flag_reg;
        unique case (pos_eff)
            POS_T_HI, POS_H_HI:
            begin
                crc_next  = crc_feed(crc_seed, data_byte);
                word_next = {data_byte, 8'h00};
                pos_next  = frame_pos_t'(pos_eff + 3'd1);
            end
            POS_T_LO, POS_H_LO:
            begin
                crc_next  = crc_feed(crc_seed, data_byte);
                word_next = {word_reg[15:8], data_byte};
                pos_next  = frame_pos_t'(pos_eff + 3'd1);
            end
            POS_T_CRC:
            begin
                temp_flag_next = (crc_reg == data_byte);
                raw_temp_next  = word_reg;
                crc_next       = CRC_INIT;
                pos_next       = POS_H_HI;
            end
            POS_H_CRC:
            begin
                crc_next = CRC_INIT;
                pos_next = POS_T_HI;
            end
            default:
            begin
                pos_next = POS_T_HI;
                crc_next = CRC_INIT;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        res.last_byte = (pos_eff == POS_H_CRC);
        res.temp_ok   = temp_flag_reg;
        res.humi_ok   = (crc_reg == data_byte);
        res.raw_temp  = raw_temp_reg;
        res.raw_humi  = word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            word_reg      <= '0;
            raw_temp_reg  <= '0;
            temp_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            word_reg      <= word_next;
            raw_temp_reg  <= raw_temp_next;
            temp_flag_reg <= temp_flag_next;
        end
    end

endmodule

// ----- src/humidity_temp_frame_decoder_core.sv -----
// Top level of the sensor reply frame decoder: input register, frame tracker, conversion
// and result register. Depends on htfd_pkg and htfd_frame.
//
// Feed the six-byte measurement reply one byte per transaction: temperature high, low,
// check byte, humidity high, low, check byte. Each word is checked with CRC-8 (0x31,
// seed 0xFF, MSB first). The sixth byte yields one result transaction carrying temperature
// in centi-degrees C ((17500*raw)>>16)-4500, humidity in centi-percent (10000*raw)>>16,
// both check flags and an updated flag. Values refresh only when both checks pass;
// otherwise the last good values are repeated (zero before the first good frame). Raise
// frame_start with a byte to restart the frame there; a partial frame is dropped silently.
// The block takes one byte every clock cycle unless in_stall holds it; a sixth byte that is
// taken sits in the input register, then the result register loads from it, and the result
// is presented on the result ports from that register.
// Back-pressure on the result side stalls the input only when a result is waiting and
// the held byte would yield another one.
module humidity_temp_frame_decoder_core
    import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature,
    output logic [13:0]        humidity,
    output logic               temp_crc_ok,
    output logic               humi_crc_ok,
    output logic               updated
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;

    // Result register and last good values
    logic               out_valid_reg, out_valid_next;
    logic signed [14:0] temp_out_reg;
    logic [13:0]        humi_out_reg;
    logic               temp_ok_reg, humi_ok_reg, updated_reg;
    logic signed [14:0] last_temp_reg, last_temp_next;
    logic [13:0]        last_humi_reg, last_humi_next;

    frame_res_t         res;
    logic               out_ready, proc_go, take, emit, both_ok;
    logic [30:0]        temp_prod;
    logic [29:0]        humi_prod;
    logic signed [15:0] temp_wide;
    logic signed [14:0] temp_conv;
    logic [13:0]        humi_conv;

    // Result register is free when empty or being drained this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    // Advance the held byte unless it closes a frame and the result register is busy
    assign proc_go   = in_valid_reg && (!res.last_byte || out_ready);
    assign emit      = proc_go && res.last_byte;
    assign in_stall  = in_valid_reg && !proc_go;
    assign take      = in_valid && !in_stall;

    htfd_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (proc_go),
        .data_byte   (byte_reg),
        .frame_start (start_reg),
        .res         (res)
    );

    // Scale the raw words; one constant multiply each
    assign temp_prod = {16'b0, TEMP_SCALE} * {15'b0, res.raw_temp};
    assign humi_prod = {16'b0, HUMI_SCALE} * {14'b0, res.raw_humi};
    assign temp_wide = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
    assign temp_conv = temp_wide[14:0];
    assign humi_conv = humi_prod[29:16];
    assign both_ok   = res.temp_ok && res.humi_ok;

    // Refresh the last good values only on a fully checked frame
    always_comb
    begin
        last_temp_next = last_temp_reg;
        last_humi_next = last_humi_reg;
        if (emit && both_ok)
        begin
            last_temp_next = temp_conv;
            last_humi_next = humi_conv;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_temp_reg <= '0;
            last_humi_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            last_temp_reg <= last_temp_next;
            last_humi_reg <= last_humi_next;
        end
    end

    // Payload registers: load on acceptance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg  <= data_byte;
            start_reg <= frame_start;
        end
        if (emit)
        begin
            temp_out_reg <= last_temp_next;
            humi_out_reg <= last_humi_next;
            temp_ok_reg  <= res.temp_ok;
            humi_ok_reg  <= res.humi_ok;
            updated_reg  <= both_ok;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temp_out_reg;
    assign humidity    = humi_out_reg;
    assign temp_crc_ok = temp_ok_reg;
    assign humi_crc_ok = humi_ok_reg;
    assign updated     = updated_reg;

endmodule

// ----- src/htfd_checker.sv -----
// Port-level checker for the sensor frame decoder, bound to the top level.
// Depends on htfd_pkg and humidity_temp_frame_decoder_core.
module htfd_checker
    import htfd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [14:0] temperature,
    input logic [13:0]        humidity,
    input logic               temp_crc_ok,
    input logic               humi_crc_ok,
    input logic               updated
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature) && $stable(humidity)
            && $stable(updated))
        else $error("result changed while stalled");

    // Refresh only on both checks passing
    a_updated_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && updated |-> temp_crc_ok && humi_crc_ok)
        else $error("updated without both checks");

    // Converted values stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature >= TEMP_MIN) && (temperature <= TEMP_MAX)
            && (humidity <= HUMI_MAX))
        else $error("converted value out of range");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid after reset");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .humidity    (humidity),
    .temp_crc_ok (temp_crc_ok),
    .humi_crc_ok (humi_crc_ok),
    .updated     (updated)
);

// ----- tb/tb_humidity_temp_frame_decoder_core.sv -----
// Self-checking bench for humidity_temp_frame_decoder_core: directed and random sensor replies
// are checked against an in-bench model of the CRC-8 frame check and the unit conversion.
// Depends on htfd_pkg and the decoder RTL only.
module tb_humidity_temp_frame_decoder_core;

    import htfd_pkg::*;

    // One result transaction as the decoder presents it
    typedef struct {
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
        logic               temp_ok;
        logic               humi_ok;
        logic               updated;
    } reading_t;

    // Scoreboard: tracks the frame as the decoder should and queues the expected readings
    class frame_scoreboard;
        frame_pos_t  pos;
        logic [7:0]  crc;
        logic [15:0] word;
        logic [15:0] raw_temp;
        logic        temp_match;
        logic [15:0] good_temp;
        logic [13:0] good_humi;
        reading_t    expected_readings[$];
        int          errors;

        function new();
            pos        = POS_T_HI;
            crc        = CRC_INIT;
            word       = '0;
            raw_temp   = '0;
            temp_match = 1'b0;
            good_temp  = '0;
            good_humi  = '0;
            errors     = 0;
        endfunction

        // Bit-serial CRC-8, polynomial 0x31, MSB first
        function logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ b[i];
                r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function logic [7:0] word_crc(input logic [15:0] w);
            return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Advance the frame model by one accepted byte
        function void note_byte(input logic [7:0] b, input logic start);
            logic        humi_match;
            logic        both;
            logic [31:0] prod;
            int          t;
            reading_t    r;
            if (start)
            begin
                pos = POS_T_HI;
                crc = CRC_INIT;
            end
            case (pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc  = crc8_step(CRC_INIT, b);
                    word = {b, 8'h00};
                    pos  = (pos == POS_T_HI) ? POS_T_LO : POS_H_LO;
                end
                POS_T_LO, POS_H_LO:
                begin
                    crc       = crc8_step(crc, b);
                    word[7:0] = b;
                    pos       = (pos == POS_T_LO) ? POS_T_CRC : POS_H_CRC;
                end
                POS_T_CRC:
                begin
                    temp_match = (crc == b);
                    raw_temp   = word;
                    crc        = CRC_INIT;
                    pos        = POS_H_HI;
                end
                default:
                begin
                    humi_match = (crc == b);
                    both       = temp_match && humi_match;
                    if (both)
                    begin
                        prod      = 32'(TEMP_SCALE) * 32'(raw_temp);
                        t         = int'(prod >> 16) - int'(TEMP_OFFSET);
                        good_temp = t[15:0];
                        prod      = 32'(HUMI_SCALE) * 32'(word);
                        good_humi = prod[29:16];
                    end
                    r.temperature = good_temp[14:0];
                    r.humidity    = good_humi;
                    r.temp_ok     = temp_match;
                    r.humi_ok     = humi_match;
                    r.updated     = both;
                    expected_readings.push_back(r);
                    pos = POS_T_HI;
                    crc = CRC_INIT;
                end
            endcase
        endfunction

        function void compare_field(input string field, input int want, input int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // Check one accepted result against the oldest expectation
        function void check_reading(input reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual temperature %0d",
                         $time, got.temperature);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("temperature", int'(want.temperature), int'(got.temperature));
            compare_field("humidity", int'(want.humidity), int'(got.humidity));
            compare_field("temp_crc_ok", int'(want.temp_ok), int'(got.temp_ok));
            compare_field("humi_crc_ok", int'(want.humi_ok), int'(got.humi_ok));
            compare_field("updated", int'(want.updated), int'(got.updated));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic               temp_crc_ok;
    logic               humi_crc_ok;
    logic               updated;

    frame_scoreboard sb = new();

    // Idle percentages for the sender and the receiver, changed per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int bytes_sent  = 0;
    // Force a start mark on the next frame after a deliberately broken one
    bit resync_due  = 1'b0;

    humidity_temp_frame_decoder_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .temperature (temperature),
        .humidity    (humidity),
        .temp_crc_ok (temp_crc_ok),
        .humi_crc_ok (humi_crc_ok),
        .updated     (updated)
    );

    always #10 clk = ~clk;

    // Receiver back-pressure: stall at random according to the current phase
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Monitor both channels; every signal here was last written by a nonblocking update,
    // so the values seen at the edge are those the decoder sampled
    always @(posedge clk)
    begin
        reading_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_byte(data_byte, frame_start);
            end
            if (out_valid && !out_stall)
            begin
                got.temperature = temperature;
                got.humidity    = humidity;
                got.temp_ok     = temp_crc_ok;
                got.humi_ok     = humi_crc_ok;
                got.updated     = updated;
                sb.check_reading(got);
            end
        end
    end

    // Present one byte, idling first at random, and hold it until the transaction completes
    task automatic drive_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= start;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Send a whole reply; corrupt either check byte on request
    task automatic send_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                              input bit bad_t, input bit bad_h, input logic mark);
        logic [7:0] flip_t;
        logic [7:0] flip_h;
        flip_t = bad_t ? 8'($urandom_range(1, 255)) : 8'h00;
        flip_h = bad_h ? 8'($urandom_range(1, 255)) : 8'h00;
        drive_byte(raw_t[15:8], mark);
        drive_byte(raw_t[7:0], 1'b0);
        drive_byte(sb.word_crc(raw_t) ^ flip_t, 1'b0);
        drive_byte(raw_h[15:8], 1'b0);
        drive_byte(raw_h[7:0], 1'b0);
        drive_byte(sb.word_crc(raw_h) ^ flip_h, 1'b0);
    endtask

    // Hold the sender until every expected reading has come, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_raw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            return 16'h0000;
        end
        if (r < 8)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Random traffic until the byte count reaches the given total
    task automatic random_traffic(input int upto);
        int         r;
        int         n;
        logic [15:0] w;
        logic [7:0] c;
        while (bytes_sent < upto)
        begin
            r = $urandom_range(0, 99);
            if (r < 76)
            begin
                // well-formed reply with random content, mostly with a start mark
                send_frame(pick_raw(), pick_raw(),
                           $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12,
                           resync_due || ($urandom_range(0, 99) < 70));
                resync_due = 1'b0;
            end
            else if (r < 89)
            begin
                // broken reply: abandon it part way and restart on the next frame
                w = pick_raw();
                c = sb.word_crc(w);
                n = $urandom_range(1, 5);
                drive_byte(w[15:8], 1'b1);
                if (n > 1) drive_byte(w[7:0], 1'b0);
                if (n > 2) drive_byte(c, 1'b0);
                if (n > 3) drive_byte(8'($urandom), 1'b0);
                if (n > 4) drive_byte(8'($urandom), 1'b0);
                resync_due = 1'b1;
            end
            else
            begin
                // line noise with stray start marks
                n = $urandom_range(1, 4);
                repeat (n) drive_byte(8'($urandom), $urandom_range(0, 3) == 0);
                resync_due = 1'b1;
            end
        end
    endtask

    initial
    begin
        int third;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: before any good frame the values read zero
        send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
        // lowest raw words: -45.00 C, 0 %
        send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
        // highest raw words with a start mark on the frame boundary
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        // partial frame dropped by a start mark mid-frame, then humidity check fails
        drive_byte(8'h12, 1'b1);
        drive_byte(8'h34, 1'b0);
        send_frame(16'hA5C3, 16'h5A3C, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // Random phases: sender idles lightly and receiver heavily, then swapped, then none
        third = (1850 - bytes_sent) / 3;
        tx_idle_pct = 22;
        rx_idle_pct = 67;
        random_traffic(bytes_sent + third);
        wait_drained();
        tx_idle_pct = 67;
        rx_idle_pct = 22;
        random_traffic(bytes_sent + third);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(1850);

        // Drain, then allow for the result latency and a margin for stray results
        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/htfd_pkg.sv
src/htfd_frame.sv
src/humidity_temp_frame_decoder_core.sv
src/htfd_checker.sv
tb/tb_humidity_temp_frame_decoder_core.sv
